/* src/boundary_face_extract_dedup_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the boundary face extraction block
// Shared shorthand for clocked implication checks, disabled while reset is held.
// ---------------------------------------------------------------------------
`ifndef BOUNDARY_FACE_EXTRACT_DEDUP_MACROS_SVH
`define BOUNDARY_FACE_EXTRACT_DEDUP_MACROS_SVH

// Same-cycle implication
`define BFED_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfed check failed");

// Next-cycle implication
`define BFED_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfed check failed");

`endif

/* src/bfed_pkg.sv */
// ---------------------------------------------------------------------------
// bfed_pkg
// Constants, face-vertex table, FSM state and control/status bundles.
// ---------------------------------------------------------------------------
package bfed_pkg;

  localparam int FACE_CAPACITY = 4096;
  localparam int NODE_W        = 32;
  localparam int TAG_W         = 8;
  localparam int WORD_W        = 32;
  localparam int FACES         = 4;
  localparam int FACE_W        = $clog2(FACES);
  localparam int ADDR_W        = $clog2(FACE_CAPACITY);
  localparam int COUNT_W       = $clog2(FACE_CAPACITY + 1);
  localparam int KEY_W         = 3 * NODE_W;
  localparam int RES_W         = $clog2(FACES + 1);

  localparam logic STATUS_STORED  = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  // Vertex picks per face, in emission order
  localparam logic [1:0] FACE_VERTEX [FACES][3] = '{
    '{2'd0, 2'd2, 2'd1},
    '{2'd0, 2'd1, 2'd3},
    '{2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd3, 2'd2}
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_INSERT,
    ST_ADVANCE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic scan;
    logic insert;
    logic advance;
    logic emit_start;
    logic emit_next;
  } cmd_t;

  typedef struct packed {
    logic tag_zero;
    logic hit;
    logic scan_done;
    logic last_face;
    logic res_empty;
    logic emit_last;
  } status_t;

endpackage

/* src/bfed_ctrl.sv */
// ---------------------------------------------------------------------------
// bfed_ctrl
// Sequencer: walks the four faces, runs the key scan, then drains results.
// ---------------------------------------------------------------------------
module bfed_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bfed_pkg::status_t sts,
  output bfed_pkg::cmd_t    cmd
);
  import bfed_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        state_next = sts.tag_zero ? ST_ADVANCE : ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.hit) state_next = ST_ADVANCE;
        else if (sts.scan_done) state_next = ST_INSERT;
      end
      ST_INSERT: begin
        state_next = ST_ADVANCE;
      end
      ST_ADVANCE: begin
        if (!sts.last_face) state_next = ST_SETUP;
        else if (sts.res_empty) state_next = ST_IDLE;
        else state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready && sts.emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        // no request taken while reset is held
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      ST_SETUP: begin
        cmd.setup = !sts.tag_zero;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
      end
      ST_ADVANCE: begin
        cmd.advance    = !sts.last_face;
        cmd.emit_start = sts.last_face && !sts.res_empty;
      end
      ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.emit_next = out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* src/bfed_datapath.sv */
// ---------------------------------------------------------------------------
// bfed_datapath
// Item registers, key sorter, stored-face memory with scan, result buffer.
// ---------------------------------------------------------------------------
module bfed_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  bfed_pkg::cmd_t                 cmd,
  output bfed_pkg::status_t              sts,
  input  logic [bfed_pkg::NODE_W-1:0]    node_zero,
  input  logic [bfed_pkg::NODE_W-1:0]    node_one,
  input  logic [bfed_pkg::NODE_W-1:0]    node_two,
  input  logic [bfed_pkg::NODE_W-1:0]    node_three,
  input  logic [bfed_pkg::WORD_W-1:0]    boundary_word,
  output logic [bfed_pkg::NODE_W-1:0]    face_node_a,
  output logic [bfed_pkg::NODE_W-1:0]    face_node_b,
  output logic [bfed_pkg::NODE_W-1:0]    face_node_c,
  output logic [bfed_pkg::TAG_W-1:0]     face_tag,
  output logic                           status,
  output logic                           last
);
  import bfed_pkg::*;

  // Item registers
  logic [NODE_W-1:0]  nodes [FACES];
  logic [WORD_W-1:0]  word;
  logic [FACE_W-1:0]  face_idx;

  // Current face
  logic [NODE_W-1:0]  cur_a, cur_b, cur_c;
  logic [TAG_W-1:0]   cur_tag;
  logic [KEY_W-1:0]   cur_key;

  // Key table
  logic [KEY_W-1:0]   key_mem [FACE_CAPACITY];
  logic [KEY_W-1:0]   rd_data;
  logic [COUNT_W-1:0] stored_count;
  logic [COUNT_W-1:0] scan_ptr;
  logic               rd_pend;
  logic               table_full;

  // Result buffer
  logic [NODE_W-1:0]  res_a      [FACES];
  logic [NODE_W-1:0]  res_b      [FACES];
  logic [NODE_W-1:0]  res_c      [FACES];
  logic [TAG_W-1:0]   res_tag    [FACES];
  logic               res_status [FACES];
  logic [RES_W-1:0]   res_count;
  logic [FACE_W-1:0]  emit_idx;
  logic               emit_last;

  // Face selection and three-way sort (parallel compares)
  logic [NODE_W-1:0]  sel_a, sel_b, sel_c;
  logic [NODE_W-1:0]  srt_lo, srt_mid, srt_hi;
  logic [TAG_W-1:0]   sel_tag;
  logic               le_ab, le_ac, le_bc;

  always_comb begin
    sel_a   = nodes[FACE_VERTEX[face_idx][0]];
    sel_b   = nodes[FACE_VERTEX[face_idx][1]];
    sel_c   = nodes[FACE_VERTEX[face_idx][2]];
    sel_tag = word[face_idx * TAG_W +: TAG_W];
    le_ab   = sel_a <= sel_b;
    le_ac   = sel_a <= sel_c;
    le_bc   = sel_b <= sel_c;
    srt_lo  = le_ab ? (le_ac ? sel_a : sel_c) : (le_bc ? sel_b : sel_c);
    srt_hi  = le_ab ? (le_bc ? sel_c : sel_b) : (le_ac ? sel_c : sel_a);
    srt_mid = le_ab ? (le_bc ? sel_b : (le_ac ? sel_c : sel_a))
                    : (le_ac ? sel_a : (le_bc ? sel_c : sel_b));
  end

  // Item capture and face walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nodes[0] <= node_zero;
      nodes[1] <= node_one;
      nodes[2] <= node_two;
      nodes[3] <= node_three;
      word     <= boundary_word;
      face_idx <= '0;
    end else if (cmd.advance) begin
      face_idx <= face_idx + FACE_W'(1);
    end
  end

  // Current face latch
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      cur_a   <= sel_a;
      cur_b   <= sel_b;
      cur_c   <= sel_c;
      cur_tag <= sel_tag;
      cur_key <= {srt_hi, srt_mid, srt_lo};
    end
  end

  assign table_full = stored_count == COUNT_W'(FACE_CAPACITY);

  // Key memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.insert && !table_full) begin
      key_mem[stored_count[ADDR_W-1:0]] <= cur_key;
    end
    rd_data <= key_mem[scan_ptr[ADDR_W-1:0]];
  end

  // Scan pointer: one stored key per cycle, compared in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend  <= 1'b0;
      scan_ptr <= '0;
    end else if (cmd.setup) begin
      rd_pend  <= 1'b0;
      scan_ptr <= '0;
    end else if (cmd.scan) begin
      if (scan_ptr != stored_count) begin
        scan_ptr <= scan_ptr + COUNT_W'(1);
        rd_pend  <= 1'b1;
      end else begin
        rd_pend  <= 1'b0;
      end
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
    end else if (cmd.insert && !table_full) begin
      stored_count <= stored_count + COUNT_W'(1);
    end
  end

  // Result buffer writes
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      res_a[res_count[FACE_W-1:0]]      <= cur_a;
      res_b[res_count[FACE_W-1:0]]      <= cur_b;
      res_c[res_count[FACE_W-1:0]]      <= cur_c;
      res_tag[res_count[FACE_W-1:0]]    <= cur_tag;
      res_status[res_count[FACE_W-1:0]] <= table_full ? STATUS_DROPPED : STATUS_STORED;
    end
  end

  // Result count and drain index
  always_ff @(posedge clk) begin
    if (rst) begin
      res_count <= '0;
      emit_idx  <= '0;
    end else begin
      if (cmd.load) begin
        res_count <= '0;
      end else if (cmd.insert) begin
        res_count <= res_count + RES_W'(1);
      end
      if (cmd.emit_start) begin
        emit_idx <= '0;
      end else if (cmd.emit_next) begin
        emit_idx <= emit_idx + FACE_W'(1);
      end
    end
  end

  assign emit_last = {1'b0, emit_idx} == (res_count - RES_W'(1));

  // Result outputs
  assign face_node_a = res_a[emit_idx];
  assign face_node_b = res_b[emit_idx];
  assign face_node_c = res_c[emit_idx];
  assign face_tag    = res_tag[emit_idx];
  assign status      = res_status[emit_idx];
  assign last        = emit_last;

  // Status to the sequencer
  always_comb begin
    sts.tag_zero  = sel_tag == '0;
    sts.hit       = rd_pend && (rd_data == cur_key);
    sts.scan_done = (scan_ptr == stored_count) && !rd_pend;
    sts.last_face = face_idx == FACE_W'(FACES - 1);
    sts.res_empty = res_count == '0;
    sts.emit_last = emit_last;
  end

endmodule

/* src/boundary_face_extract_dedup.sv */
// ---------------------------------------------------------------------------
// boundary_face_extract_dedup
// Boundary face extraction with deduplication for tetrahedral meshes.
// ---------------------------------------------------------------------------
// One tetrahedron is taken per request; faces 0 to 3 are visited in order and
// each face with a nonzero tag has its sorted node triple looked up in a
// 4096-entry key memory by a linear scan through its single read port, one
// stored key per cycle. A new face is stored and sent out in face-table node
// order with its tag; once the memory is full, new faces go out marked
// dropped. Results of a request are buffered and delivered after all four
// faces are done, the final one flagged last. The next request is taken only
// after the last result has gone.
// ---------------------------------------------------------------------------
module boundary_face_extract_dedup (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bfed_pkg::NODE_W-1:0]    node_zero,
  input  logic [bfed_pkg::NODE_W-1:0]    node_one,
  input  logic [bfed_pkg::NODE_W-1:0]    node_two,
  input  logic [bfed_pkg::NODE_W-1:0]    node_three,
  input  logic [bfed_pkg::WORD_W-1:0]    boundary_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bfed_pkg::NODE_W-1:0]    face_node_a,
  output logic [bfed_pkg::NODE_W-1:0]    face_node_b,
  output logic [bfed_pkg::NODE_W-1:0]    face_node_c,
  output logic [bfed_pkg::TAG_W-1:0]     face_tag,
  output logic                           status,
  output logic                           last
);
  import bfed_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // Sequencer
  bfed_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath
  bfed_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .node_zero     (node_zero),
    .node_one      (node_one),
    .node_two      (node_two),
    .node_three    (node_three),
    .boundary_word (boundary_word),
    .face_node_a   (face_node_a),
    .face_node_b   (face_node_b),
    .face_node_c   (face_node_c),
    .face_tag      (face_tag),
    .status        (status),
    .last          (last)
  );

endmodule

/* src/bfed_checker.sv */
// ---------------------------------------------------------------------------
// bfed_checker
// Port-level checks on request flow and result draining, bound to the top.
// ---------------------------------------------------------------------------
`include "boundary_face_extract_dedup_macros.svh"

module bfed_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [bfed_pkg::NODE_W-1:0]    face_node_a,
  input logic [bfed_pkg::NODE_W-1:0]    face_node_b,
  input logic [bfed_pkg::NODE_W-1:0]    face_node_c,
  input logic [bfed_pkg::TAG_W-1:0]     face_tag,
  input logic                           status,
  input logic                           last
);
  import bfed_pkg::*;

  // No new request while results are still draining
  `BFED_ASSERT_SAME(a_no_overlap, clk, rst, in_ready, !out_valid)

  // A taken request is not followed by another in the next cycle
  `BFED_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)

  // Results of one request come out back to back up to the last one
  `BFED_ASSERT_NEXT(a_burst, clk, rst, out_valid && out_ready && !last, out_valid)

  // Only tagged faces are ever reported
  `BFED_ASSERT_SAME(a_tag_nonzero, clk, rst, out_valid, face_tag != '0)

  // A stalled result holds
  `BFED_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(face_node_a) && $stable(face_node_b) && $stable(face_node_c)
    && $stable(face_tag) && $stable(status) && $stable(last))

endmodule

bind boundary_face_extract_dedup bfed_checker u_bfed_checker (.*);
